// File: rtl/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and codes for the periodic and timeout timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int OPCODE_W = 3;
  localparam int INDEX_W  = 3;
  localparam int LOAD_W   = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_LOAD  = 3'd4,
    OP_QUERY = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TICK = 3'b010,
    S_RESP = 3'b100
  } state_t;

  typedef struct packed {
    logic timeout_expired;
    logic periodic_done;
  } result_t;

endpackage

// File: rtl/ptb_out_stage.sv
// ----------------------------------------------------------------------------
// ptb_out_stage
// Output register of the timer bank: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module ptb_out_stage
  import ptb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  result_t                result,
  output logic                   free,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata   // [0] periodic_done, [1] timeout_expired
);

  result_t held;

  // the register can take a new result when empty or drained this cycle
  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-2){1'b0}}, held.timeout_expired, held.periodic_done};

endmodule

// File: rtl/periodic_and_timeout_timer_bank.sv
// ----------------------------------------------------------------------------
// periodic_and_timeout_timer_bank
// Bank of periodic counters and one-shot timeout counters kept in two
// simple dual-port synchronous memories, updated by a read-modify-write walk.
// ----------------------------------------------------------------------------
// sequence: a non-tick transaction goes straight to the response state; a tick
//   walks both memories one entry per cycle, waits for the last write-back, then
//   responds; the result is registered in the output stage once that stage is free
// throughput: one transaction at a time; the next one is taken the cycle
//   after the previous result is registered, even while that result waits
// reset: control state and the per-entry active, done and nonzero bits clear
//   at once; memory contents are only read behind those bits, so no sweep
module periodic_and_timeout_timer_bank
  import ptb_pkg::*;
#(
  parameter int NUM_PERIODIC = 8,
  parameter int NUM_TIMEOUT  = 8,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [2:0] opcode, [5:3] entry_index, [21:6] load_value
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [0] periodic_done, [1] timeout_expired
);

  localparam int NMAX  = (NUM_PERIODIC > NUM_TIMEOUT) ? NUM_PERIODIC : NUM_TIMEOUT;
  localparam int NP_AW = (NUM_PERIODIC > 1) ? $clog2(NUM_PERIODIC) : 1;
  localparam int NT_AW = (NUM_TIMEOUT > 1) ? $clog2(NUM_TIMEOUT) : 1;
  localparam int CNT_W = $clog2(NMAX + 1);
  localparam int CW    = COUNT_WIDTH;

  // input fields
  logic [OPCODE_W-1:0] opcode;
  logic [INDEX_W-1:0]  entry_index;
  logic [LOAD_W-1:0]   load_value;
  logic [CW-1:0]       val;
  logic                p_ok;
  logic                t_ok;
  logic [NP_AW-1:0]    pidx;
  logic [NT_AW-1:0]    tidx;
  logic                accept;

  assign opcode      = s_tdata[2:0];
  assign entry_index = s_tdata[5:3];
  assign load_value  = s_tdata[21:6];
  assign val         = CW'(load_value);
  assign p_ok        = 32'(entry_index) < NUM_PERIODIC;
  assign t_ok        = 32'(entry_index) < NUM_TIMEOUT;
  assign pidx        = NP_AW'(entry_index);
  assign tidx        = NT_AW'(entry_index);

  state_t state;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // per-entry bits
  logic [NUM_PERIODIC-1:0] active;
  logic [NUM_PERIODIC-1:0] flag;
  logic [NUM_TIMEOUT-1:0]  nonzero;

  // held request for the result
  logic             pok_q;
  logic             tok_q;
  logic [NP_AW-1:0] pidx_q;
  logic [NT_AW-1:0] tidx_q;

  // walk counter and read stage
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] p1_idx;
  logic             p1_pv;
  logic             p1_tv;
  logic             walk_on;
  logic             p_rd;
  logic             t_rd;
  logic [NP_AW-1:0] p_rd_addr;
  logic [NT_AW-1:0] t_rd_addr;
  logic [NP_AW-1:0] p1_paddr;
  logic [NT_AW-1:0] p1_taddr;

  assign walk_on   = (state == S_TICK) && (cnt != CNT_W'(NMAX));
  assign p_rd_addr = cnt[NP_AW-1:0];
  assign t_rd_addr = cnt[NT_AW-1:0];
  assign p_rd      = walk_on && (32'(cnt) < NUM_PERIODIC) && active[p_rd_addr];
  assign t_rd      = walk_on && (32'(cnt) < NUM_TIMEOUT) && nonzero[t_rd_addr];
  assign p1_paddr  = p1_idx[NP_AW-1:0];
  assign p1_taddr  = p1_idx[NT_AW-1:0];

  // memories: periodic holds {reload, count}, timeout holds count
  logic [2*CW-1:0] pmem [NUM_PERIODIC];
  logic [CW-1:0]   tmem [NUM_TIMEOUT];
  logic [2*CW-1:0] pmem_rdata;
  logic [CW-1:0]   tmem_rdata;

  logic             pm_we;
  logic [NP_AW-1:0] pm_addr;
  logic [2*CW-1:0]  pm_wdata;
  logic             tm_we;
  logic [NT_AW-1:0] tm_addr;
  logic [CW-1:0]    tm_wdata;

  logic [CW-1:0] p_count;
  logic [CW-1:0] p_reload;
  logic [CW-1:0] p_dec;
  logic          p_wrap;
  logic [CW-1:0] t_dec;

  assign p_count  = pmem_rdata[CW-1:0];
  assign p_reload = pmem_rdata[2*CW-1:CW];
  assign p_dec    = p_count - CW'(1);
  assign p_wrap   = (p_dec == '0);
  assign t_dec    = tmem_rdata - CW'(1);

  always_comb begin
    pm_we    = 1'b0;
    pm_addr  = p1_paddr;
    pm_wdata = '0;
    tm_we    = 1'b0;
    tm_addr  = p1_taddr;
    tm_wdata = '0;
    if (accept && (opcode == OP_START) && p_ok) begin
      pm_we    = 1'b1;
      pm_addr  = pidx;
      pm_wdata = {val, val};
    end else if (p1_pv) begin
      pm_we    = 1'b1;
      pm_wdata = p_wrap ? {p_reload, p_reload} : {p_reload, p_dec};
    end
    if (accept && (opcode == OP_LOAD) && t_ok) begin
      tm_we    = 1'b1;
      tm_addr  = tidx;
      tm_wdata = val;
    end else if (p1_tv) begin
      tm_we    = 1'b1;
      tm_wdata = t_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pmem[pm_addr] <= pm_wdata;
    end
    if (p_rd) begin
      pmem_rdata <= pmem[p_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tm_we) begin
      tmem[tm_addr] <= tm_wdata;
    end
    if (t_rd) begin
      tmem_rdata <= tmem[t_rd_addr];
    end
  end

  // output register
  logic    out_free;
  logic    out_load;
  result_t result;

  assign out_load               = (state == S_RESP) && out_free;
  assign result.periodic_done   = pok_q && flag[pidx_q];
  assign result.timeout_expired = tok_q && !nonzero[tidx_q];

  ptb_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      p1_pv <= 1'b0;
      p1_tv <= 1'b0;
    end else begin
      p1_pv <= p_rd;
      p1_tv <= t_rd;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            state <= (opcode == OP_TICK) ? S_TICK : S_RESP;
          end
        end
        S_TICK: begin
          if (walk_on) begin
            cnt <= cnt + CNT_W'(1);
          end else if (!p1_pv && !p1_tv) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p1_idx <= cnt;
    if (accept) begin
      pok_q  <= p_ok;
      tok_q  <= t_ok;
      pidx_q <= pidx;
      tidx_q <= tidx;
    end
  end

  // per-entry bits: single-entry ops on acceptance, counter updates from the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= '0;
      flag    <= '0;
      nonzero <= '0;
    end else begin
      if (accept && p_ok) begin
        case (opcode)
          OP_START: begin
            active[pidx] <= 1'b1;
            flag[pidx]   <= 1'b0;
          end
          OP_STOP: begin
            active[pidx] <= 1'b0;
          end
          OP_CLEAR: begin
            flag[pidx] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (accept && t_ok && (opcode == OP_LOAD)) begin
        nonzero[tidx] <= (val != '0);
      end
      if (p1_pv && p_wrap) begin
        flag[p1_paddr] <= 1'b1;
      end
      if (p1_tv) begin
        nonzero[p1_taddr] <= (t_dec != '0);
      end
    end
  end

endmodule
